FILE: rtl/heightmap_vertex_normals_top_assert.svh
// ----------------------------------------------------------------------------
// Heightmap vertex normals assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMALS_TOP_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMALS_TOP_ASSERT_SVH

// Same-cycle implication.
`define HVN_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HVN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normals package
// Widths, register indexes, state types and controller command structures.
// ----------------------------------------------------------------------------
package hvn_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int SMP_W   = 8;
    localparam int GAIN_W  = 16;
    localparam int HGT_W   = SMP_W + GAIN_W;
    localparam int VEC_W   = HGT_W + 1;
    localparam int NRM_W   = 16;
    localparam int POS_W   = 8;
    localparam int DIM_W   = 9;
    localparam int SQ_W    = 64;
    localparam int LEN_W   = 32;
    localparam int PROD_W  = 2 * VEC_W;
    localparam int FRAC_SHIFT = 21;
    localparam int QUO_W   = 15;
    localparam int DEN_SHIFT  = QUO_W - 1;
    localparam int NUM_W   = VEC_W + FRAC_SHIFT + 1;
    localparam int ROOT_SHIFT = 12;
    localparam int ROOT_STEPS = 32;
    localparam int CNT_W   = 5;
    localparam int FACE_Y  = 65536;
    localparam int NRM_MAX = 16384;

    localparam int ADDR_W  = 4;
    localparam int APB_W   = 32;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HEIGHT_GAIN = 2'd2;

    localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 9'd256;
    localparam logic [GAIN_W-1:0] HEIGHT_GAIN_RST = 16'd5461;

    typedef struct packed {
        logic signed [NRM_W-1:0] z;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] x;
    } t_face;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_FACE,
        ST_VSEL,
        ST_VWAIT,
        ST_EMIT,
        ST_UPD_A,
        ST_UPD_B
    } t_state;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SQ,
        NS_ROOT,
        NS_DLOAD,
        NS_DIV,
        NS_DONE
    } t_norm_state;

    typedef struct packed {
        logic       accept;
        logic       mul;
        logic       face_start;
        logic       face_keep;
        logic       vert_start;
        logic       out_load;
        logic       out_last;
        logic       upd_a;
        logic       upd_b;
        logic [1:0] vidx;
    } t_cmd;

    typedef struct packed {
        logic       face_need;
        logic [3:0] vert_en;
        logic       norm_busy;
        logic       norm_done;
        logic       out_free;
    } t_sts;

endpackage

FILE: rtl/hvn_norm.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normals vector normalizer
// Iterative unit: sum of squares, bit-pair square root, and three restoring
// divisions with round-half-up and saturation to Q1.14.
// ----------------------------------------------------------------------------
module hvn_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [hvn_pkg::VEC_W-1:0]   i_vx,
    input  logic signed [hvn_pkg::VEC_W-1:0]   i_vy,
    input  logic signed [hvn_pkg::VEC_W-1:0]   i_vz,
    output logic                               o_busy,
    output logic                               o_done,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_nx,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_ny,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_nz
);
    import hvn_pkg::*;

    t_norm_state r_state, n_state;

    logic [VEC_W-1:0]        r_mag [3];
    logic [2:0]              r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic [1:0]              r_comp;
    logic [PROD_W-1:0]       r_prod;
    logic [SQ_W-1:0]         r_acc;
    logic [SQ_W-1:0]         r_rem;
    logic [SQ_W-1:0]         r_res;
    logic [SQ_W-1:0]         r_bit;
    logic [NUM_W-1:0]        r_num;
    logic [NUM_W-1:0]        r_den;
    logic [QUO_W-1:0]        r_q;
    logic signed [NRM_W-1:0] r_n [3];

    logic [VEC_W-1:0]  sq_in;
    logic [SQ_W-1:0]   sq_try;
    logic              sq_ge;
    logic              dv_ge;
    logic [QUO_W-1:0]  q_next;
    logic [QUO_W-1:0]  q_sat;
    logic [LEN_W-1:0]  len;

    assign len    = r_res[LEN_W-1:0];
    assign sq_try = r_res + r_bit;
    assign sq_ge  = (r_rem >= sq_try);
    assign dv_ge  = (r_num >= r_den);
    assign q_next = {r_q[QUO_W-2:0], dv_ge};
    assign q_sat  = (int'(q_next) > NRM_MAX) ? QUO_W'(NRM_MAX) : q_next;

    always_comb begin
        case (r_cnt[1:0])
            2'd1:    sq_in = r_mag[1];
            2'd2:    sq_in = r_mag[2];
            default: sq_in = r_mag[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            NS_IDLE:  if (i_start) n_state = NS_SQ;
            NS_SQ:    if (r_cnt == CNT_W'(3)) n_state = NS_ROOT;
            NS_ROOT:  if (r_cnt == CNT_W'(ROOT_STEPS - 1)) n_state = NS_DLOAD;
            NS_DLOAD: n_state = (len == '0) ? NS_DONE : NS_DIV;
            NS_DIV: begin
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = (r_comp == 2'd2) ? NS_DONE : NS_DLOAD;
                end
            end
            NS_DONE:  n_state = NS_IDLE;
            default:  n_state = NS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            NS_IDLE: begin
                if (i_start) begin
                    r_mag[0] <= i_vx[VEC_W-1] ? VEC_W'(-i_vx) : VEC_W'(i_vx);
                    r_mag[1] <= i_vy[VEC_W-1] ? VEC_W'(-i_vy) : VEC_W'(i_vy);
                    r_mag[2] <= i_vz[VEC_W-1] ? VEC_W'(-i_vz) : VEC_W'(i_vz);
                    r_neg    <= {i_vz[VEC_W-1], i_vy[VEC_W-1], i_vx[VEC_W-1]};
                    r_cnt    <= '0;
                    r_acc    <= '0;
                end
            end
            NS_SQ: begin
                r_prod <= sq_in * sq_in;
                r_acc  <= r_acc + ((r_cnt == '0) ? '0 : SQ_W'(r_prod));
                if (r_cnt == CNT_W'(3)) begin
                    r_rem <= (r_acc + SQ_W'(r_prod)) << ROOT_SHIFT;
                    r_res <= '0;
                    r_bit <= SQ_W'(1) << (SQ_W - 2);
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            NS_ROOT: begin
                r_rem  <= sq_ge ? (r_rem - sq_try) : r_rem;
                r_res  <= sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + 1'b1;
                r_comp <= '0;
            end
            NS_DLOAD: begin
                r_num <= NUM_W'({r_mag[r_comp], FRAC_SHIFT'(0)}) + NUM_W'(len);
                r_den <= NUM_W'({len, 1'b0}) << DEN_SHIFT;
                r_q   <= '0;
                r_cnt <= '0;
                if (len == '0) begin
                    r_n[0] <= '0;
                    r_n[1] <= '0;
                    r_n[2] <= '0;
                end
            end
            NS_DIV: begin
                r_num <= dv_ge ? (r_num - r_den) : r_num;
                r_den <= r_den >> 1;
                r_q   <= q_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_n[r_comp] <= r_neg[r_comp] ? -NRM_W'(q_sat) : NRM_W'(q_sat);
                    r_comp      <= r_comp + 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_busy = (r_state != NS_IDLE);
    assign o_done = (r_state == NS_DONE);
    assign o_nx   = r_n[0];
    assign o_ny   = r_n[1];
    assign o_nz   = r_n[2];

endmodule

FILE: rtl/hvn_dp.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normals datapath
// Height scaling, line buffers, grid position, vertex sums, normalizer and
// the output register.
// ----------------------------------------------------------------------------
module hvn_dp #(
    parameter int MAX_WIDTH  = hvn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hvn_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  hvn_pkg::t_cmd                      i_cmd,
    output hvn_pkg::t_sts                      o_sts,
    input  logic [hvn_pkg::SMP_W-1:0]          i_sample,
    input  logic [hvn_pkg::DIM_W-1:0]          i_grid_width,
    input  logic [hvn_pkg::DIM_W-1:0]          i_grid_height,
    input  logic [hvn_pkg::GAIN_W-1:0]         i_height_gain,
    input  logic                               i_pos_clr,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_nx,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_ny,
    output logic signed [hvn_pkg::NRM_W-1:0]   o_nz,
    output logic [hvn_pkg::POS_W-1:0]          o_row,
    output logic [hvn_pkg::POS_W-1:0]          o_col,
    output logic                               o_last
);
    import hvn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [HGT_W-1:0] h_mem [MAX_WIDTH];
    t_face            f_mem [MAX_WIDTH-1];

    logic [SMP_W-1:0] r_sample;
    logic [HGT_W-1:0] r_cur;
    logic [HGT_W-1:0] r_left_h;
    logic [HGT_W-1:0] r_up_h;
    t_face            r_up_f;
    t_face            r_left_f;
    t_face            r_ul_f;
    t_face            r_face;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;

    logic [CW-1:0] wl;
    logic [RW-1:0] hl;
    logic [CW-1:0] col;
    logic          last_col;
    logic          last_row;
    logic          has_up;
    logic          has_left;
    logic          use_up;
    logic          use_ul;
    logic          use_left;

    logic signed [VEC_W-1:0] sx, sy, sz;
    logic signed [VEC_W-1:0] vx, vy, vz;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic                    norm_busy;
    logic                    norm_done;
    logic                    out_free;
    t_face                   face_res;

    always_comb begin
        if (i_grid_width < DIM_W'(2)) begin
            wl = CW'(1);
        end else if (int'(i_grid_width) > MAX_WIDTH) begin
            wl = CW'(MAX_WIDTH - 1);
        end else begin
            wl = CW'(i_grid_width - 1'b1);
        end
        if (i_grid_height < DIM_W'(2)) begin
            hl = RW'(1);
        end else if (int'(i_grid_height) > MAX_HEIGHT) begin
            hl = RW'(MAX_HEIGHT - 1);
        end else begin
            hl = RW'(i_grid_height - 1'b1);
        end
    end

    assign col      = (r_col > wl) ? wl : r_col;
    assign last_col = (col == wl);
    assign last_row = (r_row >= hl);
    assign has_up   = (int'(r_row) >= 2);
    assign has_left = (int'(col) >= 2);

    always_comb begin
        case (i_cmd.vidx)
            2'd0: begin
                use_up   = has_up;
                use_ul   = has_up && has_left;
                use_left = has_left;
            end
            2'd1: begin
                use_up   = has_up;
                use_ul   = 1'b0;
                use_left = 1'b0;
            end
            2'd2: begin
                use_up   = 1'b0;
                use_ul   = 1'b0;
                use_left = has_left;
            end
            default: begin
                use_up   = 1'b0;
                use_ul   = 1'b0;
                use_left = 1'b0;
            end
        endcase
        sx = VEC_W'(r_face.x) + (use_up ? VEC_W'(r_up_f.x) : '0)
           + (use_ul ? VEC_W'(r_ul_f.x) : '0) + (use_left ? VEC_W'(r_left_f.x) : '0);
        sy = VEC_W'(r_face.y) + (use_up ? VEC_W'(r_up_f.y) : '0)
           + (use_ul ? VEC_W'(r_ul_f.y) : '0) + (use_left ? VEC_W'(r_left_f.y) : '0);
        sz = VEC_W'(r_face.z) + (use_up ? VEC_W'(r_up_f.z) : '0)
           + (use_ul ? VEC_W'(r_ul_f.z) : '0) + (use_left ? VEC_W'(r_left_f.z) : '0);
        if (i_cmd.face_start) begin
            vx = $signed({1'b0, r_left_h}) - $signed({1'b0, r_cur});
            vy = VEC_W'(FACE_Y);
            vz = $signed({1'b0, r_left_h}) - $signed({1'b0, r_up_h});
        end else begin
            vx = sx;
            vy = sy;
            vz = sz;
        end
    end

    hvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.face_start || i_cmd.vert_start),
        .i_vx    (vx),
        .i_vy    (vy),
        .i_vz    (vz),
        .o_busy  (norm_busy),
        .o_done  (norm_done),
        .o_nx    (nx),
        .o_ny    (ny),
        .o_nz    (nz)
    );

    assign face_res = '{z: nz, y: ny, x: nx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_up_h   <= h_mem[col - 1'b1];
            r_up_f   <= f_mem[col - 1'b1];
        end
        if (i_cmd.mul) begin
            r_cur <= r_sample * i_height_gain;
        end
        if (i_cmd.face_keep) begin
            r_face <= face_res;
        end
        if (i_cmd.upd_a && o_sts.face_need) begin
            f_mem[col - 1'b1] <= r_face;
        end
        if (i_cmd.upd_a && (col != '0)) begin
            h_mem[col - 1'b1] <= r_left_h;
        end else if (i_cmd.upd_b && last_col) begin
            h_mem[col] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_h <= '0;
            r_left_f <= '0;
            r_ul_f   <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cmd.upd_a && o_sts.face_need) begin
                r_ul_f   <= r_up_f;
                r_left_f <= r_face;
            end
            if (i_pos_clr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.upd_b) begin
                r_left_h <= r_cur;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= col + 1'b1;
                end
            end
        end
    end

    assign out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_nx   <= nx;
            o_ny   <= ny;
            o_nz   <= nz;
            o_row  <= POS_W'(i_cmd.vidx[1] ? r_row : r_row - 1'b1);
            o_col  <= POS_W'(i_cmd.vidx[0] ? col : col - 1'b1);
            o_last <= i_cmd.out_last;
        end
    end

    assign o_sts.face_need = (col != '0) && (r_row != '0);
    assign o_sts.vert_en   = {last_col && last_row, last_row, last_col, 1'b1};
    assign o_sts.norm_busy = norm_busy;
    assign o_sts.norm_done = norm_done;
    assign o_sts.out_free  = out_free;

endmodule

FILE: rtl/hvn_ctrl.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normals controller
// Sequences one sample: scale, face normal, up to four vertex normals, and
// the line buffer and position update.
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normals_top_assert.svh"

module hvn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hvn_pkg::t_sts i_sts,
    output hvn_pkg::t_cmd o_cmd
);
    import hvn_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_vidx, n_vidx;
    logic       last_vert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vidx  <= '0;
        end else begin
            r_state <= n_state;
            r_vidx  <= n_vidx;
        end
    end

    always_comb begin
        case (r_vidx)
            2'd0:    last_vert = ~|i_sts.vert_en[3:1];
            2'd1:    last_vert = ~|i_sts.vert_en[3:2];
            2'd2:    last_vert = ~i_sts.vert_en[3];
            default: last_vert = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_vidx  = r_vidx;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_MUL;
            ST_MUL:    n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_vidx  = '0;
                n_state = i_sts.face_need ? ST_FACE : ST_UPD_A;
            end
            ST_FACE:   if (i_sts.norm_done) n_state = ST_VSEL;
            ST_VSEL: begin
                if (i_sts.vert_en[r_vidx]) begin
                    n_state = ST_VWAIT;
                end else if (r_vidx == 2'd3) begin
                    n_state = ST_UPD_A;
                end else begin
                    n_vidx = r_vidx + 1'b1;
                end
            end
            ST_VWAIT:  if (i_sts.norm_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    if (last_vert) begin
                        n_state = ST_UPD_A;
                    end else begin
                        n_vidx  = r_vidx + 1'b1;
                        n_state = ST_VSEL;
                    end
                end
            end
            ST_UPD_A:  n_state = ST_UPD_B;
            ST_UPD_B:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.vidx = r_vidx;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_MUL:    o_cmd.mul = 1'b1;
            ST_DECIDE: o_cmd.face_start = i_sts.face_need;
            ST_FACE:   o_cmd.face_keep = i_sts.norm_done;
            ST_VSEL:   o_cmd.vert_start = i_sts.vert_en[r_vidx];
            ST_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.out_last = last_vert;
            end
            ST_UPD_A:  o_cmd.upd_a = 1'b1;
            ST_UPD_B:  o_cmd.upd_b = 1'b1;
            default:   o_cmd.accept = 1'b0;
        endcase
    end

    `HVN_ASSERT_IMP(a_load_free, o_cmd.out_load, i_sts.out_free, "result loaded into a full slot")
    `HVN_ASSERT_IMP(a_start_idle, o_cmd.face_start || o_cmd.vert_start, !i_sts.norm_busy, "normalizer restarted while busy")
    `HVN_ASSERT_NEXT(a_accept_mul, (r_state == ST_IDLE) && i_in_valid, r_state == ST_MUL, "accepted sample not scaled next")

endmodule

FILE: rtl/heightmap_vertex_normals_top.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normals top level
// Streams raw height samples in, averaged unit vertex normals out, with an
// APB register port for grid size and height gain.
//
// Channel     Dir  Signals                      Content
// s_axis      in   tvalid tready tdata[7:0]     height_sample
// m_axis      out  tvalid tready tdata tlast    normals, row, column, last
// apb         in   psel penable pwrite paddr    grid_width, grid_height, gain
//
// A sample with no finished face is accepted, scaled, checked and then updates
// the line buffers and position. With a face, the face normal is normalized
// first, then each enabled vertex is started, normalized and its result loaded,
// and a skipped vertex slot is passed over in the select state. The normalizer
// runs a sum of squares, a 32-step square root and three restoring divisions.
// Reset is synchronous and active low; line buffers are not cleared.
// A stalled output holds the controller only when a further result is ready.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_top #(
    parameter int MAX_WIDTH  = hvn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hvn_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // height_sample
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // normal_x, normal_y, normal_z,
                                                        // vertex_row, vertex_column
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hvn_pkg::ADDR_W-1:0]  paddr,
    input  logic [hvn_pkg::APB_W-1:0]   pwdata,
    output logic [hvn_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);
    import hvn_pkg::*;

    logic [DIM_W-1:0]  r_grid_width;
    logic [DIM_W-1:0]  r_grid_height;
    logic [GAIN_W-1:0] r_height_gain;
    logic              wr;
    logic [1:0]        idx;
    logic              pos_clr;
    t_cmd              cmd;
    t_sts              sts;
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic [POS_W-1:0]  row, col;

    assign pready  = 1'b1;
    assign idx     = paddr[3:2];
    assign wr      = psel && penable && pwrite && pready;
    assign pos_clr = wr && ((idx == REG_GRID_WIDTH) || (idx == REG_GRID_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_height_gain <= HEIGHT_GAIN_RST;
        end else if (wr) begin
            case (idx)
                REG_GRID_WIDTH:  r_grid_width  <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= pwdata[DIM_W-1:0];
                REG_HEIGHT_GAIN: r_height_gain <= pwdata[GAIN_W-1:0];
                default:         r_height_gain <= r_height_gain;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GRID_WIDTH:  prdata = APB_W'(r_grid_width);
            REG_GRID_HEIGHT: prdata = APB_W'(r_grid_height);
            REG_HEIGHT_GAIN: prdata = APB_W'(r_height_gain);
            default:         prdata = '0;
        endcase
    end

    hvn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hvn_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_sample      (s_axis_tdata),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_height_gain (r_height_gain),
        .i_pos_clr     (pos_clr),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_nx          (nx),
        .o_ny          (ny),
        .o_nz          (nz),
        .o_row         (row),
        .o_col         (col),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {col, row, nz, ny, nx};

endmodule
